// ----- sv/ultrasonic_round_robin_ranger_macros.svh -----
// Assertion helpers for the ranger; empty under synthesis.
`ifndef ULTRASONIC_ROUND_ROBIN_RANGER_MACROS_SVH
`define ULTRASONIC_ROUND_ROBIN_RANGER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset
`define URRR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("urrr: check failed");
// Next-cycle implication, disabled while in reset
`define URRR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("urrr: check failed");
`else
`define URRR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define URRR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- sv/urrr_pkg.sv -----
package urrr_pkg;

  localparam int NUM_SENSORS = 3;
  localparam int SENSOR_W    = 2;
  localparam int DATA_W      = 16;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam logic [DATA_W-1:0] NO_READING        = 16'hFFFF;
  localparam logic [DATA_W-1:0] STARTUP_RESET     = 16'd2000;
  localparam logic [DATA_W-1:0] ECHO_WAIT_RESET   = 16'd50;
  localparam logic [DATA_W-1:0] MIN_VALID_RESET   = 16'd30;

  // Register indexes (word address)
  localparam logic [1:0] REG_STARTUP   = 2'd0;
  localparam logic [1:0] REG_ECHO_WAIT = 2'd1;
  localparam logic [1:0] REG_MIN_VALID = 2'd2;

  // Request kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_RISE = 2'd1;
  localparam logic [1:0] KIND_FALL = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DATA_W-1:0] capture_time;
  } in_t;

  typedef struct packed {
    logic [NUM_SENSORS-1:0] trigger_lines;
    logic                   measure_done;
    logic [SENSOR_W-1:0]    measured_sensor;
    logic [DATA_W-1:0]      pulse_width;
    logic [DATA_W-1:0]      center_distance;
    logic [DATA_W-1:0]      left_distance;
    logic [DATA_W-1:0]      right_distance;
    logic [DATA_W-1:0]      nearest_side_distance;
  } out_t;

  // Configuration values and the start-up write strobe
  typedef struct packed {
    logic [DATA_W-1:0] startup_ticks;
    logic [DATA_W-1:0] echo_wait_ticks;
    logic [DATA_W-1:0] min_valid_distance;
    logic              startup_wr;
    logic [DATA_W-1:0] wr_value;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_STARTUP = 3'b001,
    PH_TRIGGER = 3'b010,
    PH_ECHO    = 3'b100
  } phase_t;

  // Widths at or below the limit read as no reading
  function automatic logic [DATA_W-1:0] thresholded(input logic [DATA_W-1:0] w,
                                                    input logic [DATA_W-1:0] lim);
    return (w > lim) ? w : NO_READING;
  endfunction

  // Smaller nonzero of the two side widths
  function automatic logic [DATA_W-1:0] nearest_side(input logic [DATA_W-1:0] a,
                                                     input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] res;
    if (a < b) begin
      res = (a != '0) ? a : ((b != '0) ? b : NO_READING);
    end else begin
      res = (b != '0) ? b : ((a != '0) ? a : NO_READING);
    end
    return res;
  endfunction

endpackage

// ----- sv/urrr_cfg.sv -----
module urrr_cfg import urrr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready,
  output cfg_t               cfg
);

  logic [DATA_W-1:0] startup_r;
  logic [DATA_W-1:0] echo_wait_r;
  logic [DATA_W-1:0] min_valid_r;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      startup_r   <= STARTUP_RESET;
      echo_wait_r <= ECHO_WAIT_RESET;
      min_valid_r <= MIN_VALID_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_STARTUP:   startup_r   <= cfg_pwdata[DATA_W-1:0];
        REG_ECHO_WAIT: echo_wait_r <= cfg_pwdata[DATA_W-1:0];
        REG_MIN_VALID: min_valid_r <= cfg_pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_STARTUP:   cfg_prdata = {{(PDATA_W-DATA_W){1'b0}}, startup_r};
      REG_ECHO_WAIT: cfg_prdata = {{(PDATA_W-DATA_W){1'b0}}, echo_wait_r};
      REG_MIN_VALID: cfg_prdata = {{(PDATA_W-DATA_W){1'b0}}, min_valid_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg.startup_ticks      = startup_r;
  assign cfg.echo_wait_ticks    = echo_wait_r;
  assign cfg.min_valid_distance = min_valid_r;
  assign cfg.startup_wr         = wr_en && (reg_idx == REG_STARTUP);
  assign cfg.wr_value           = cfg_pwdata[DATA_W-1:0];

endmodule

// ----- sv/ultrasonic_round_robin_ranger.sv -----
// A result is presented in the cycle after its request is accepted.
// One request per cycle while the result register is free or being drained; the
// state update and result fields are formed in a single pass into that register.
// Reset (rst_n low, synchronous): registers to 2000/50/30, start-up phase with
// the counter at 2000, sensor 0, captures, widths and triggers cleared.
`include "ultrasonic_round_robin_ranger_macros.svh"

module ultrasonic_round_robin_ranger import urrr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  cfg_t cfg;

  phase_t                 phase_r, phase_nxt;
  logic [DATA_W-1:0]      wait_r, wait_nxt, wait_dec;
  logic [SENSOR_W-1:0]    sensor_r, sensor_nxt;
  logic [DATA_W-1:0]      rise_r, rise_nxt;
  logic [DATA_W-1:0]      fall_r, fall_nxt;
  logic [DATA_W-1:0]      width_r [NUM_SENSORS];
  logic [DATA_W-1:0]      width_nxt [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] trig_r, trig_nxt;
  logic                   done;
  logic [DATA_W-1:0]      echo_width;
  logic                   out_valid_r;
  out_t                   out_data_r;
  out_t                   result;
  logic                   accept;

  urrr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Take a request whenever the result register is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign wait_dec   = (wait_r != '0) ? (wait_r - 1'b1) : wait_r;
  assign echo_width = (fall_r > rise_r) ? (fall_r - rise_r) : '0;

  // Next state for one request
  always_comb begin
    phase_nxt  = phase_r;
    wait_nxt   = wait_r;
    sensor_nxt = sensor_r;
    rise_nxt   = rise_r;
    fall_nxt   = fall_r;
    trig_nxt   = trig_r;
    done       = 1'b0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      width_nxt[i] = width_r[i];
    end
    if (accept) begin
      case (in_data.kind)
        KIND_RISE: rise_nxt = in_data.capture_time;
        KIND_FALL: fall_nxt = in_data.capture_time;
        KIND_TICK: begin
          wait_nxt = wait_dec;
          case (phase_r)
            PH_STARTUP: begin
              if (wait_dec == '0) begin
                phase_nxt = PH_TRIGGER;
              end
            end
            PH_TRIGGER: begin
              trig_nxt  = NUM_SENSORS'(1) << sensor_r;
              rise_nxt  = '0;
              fall_nxt  = '0;
              wait_nxt  = cfg.echo_wait_ticks;
              phase_nxt = PH_ECHO;
            end
            PH_ECHO: begin
              if (wait_dec == '0) begin
                for (int i = 0; i < NUM_SENSORS; i++) begin
                  if (sensor_r == SENSOR_W'(i)) begin
                    width_nxt[i] = echo_width;
                  end
                end
                done       = 1'b1;
                sensor_nxt = (sensor_r == SENSOR_W'(NUM_SENSORS - 1)) ?
                             '0 : (sensor_r + 1'b1);
                phase_nxt  = PH_TRIGGER;
              end
              trig_nxt = '0;
            end
            default: phase_nxt = PH_STARTUP;
          endcase
        end
        default: ;
      endcase
    end
    // Reload the start-up count when its register is written during start-up
    if (cfg.startup_wr && (phase_r == PH_STARTUP)) begin
      wait_nxt = cfg.wr_value;
    end
  end

  // Assemble the result from the updated state
  always_comb begin
    result.trigger_lines         = trig_nxt;
    result.measure_done          = done;
    result.measured_sensor       = done ? sensor_r : '0;
    result.pulse_width           = done ? echo_width : '0;
    result.center_distance       = thresholded(width_nxt[0], cfg.min_valid_distance);
    result.left_distance         = thresholded(width_nxt[1], cfg.min_valid_distance);
    result.right_distance        = thresholded(width_nxt[2], cfg.min_valid_distance);
    result.nearest_side_distance = nearest_side(width_nxt[1], width_nxt[2]);
  end

  // Hold the sequencing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_STARTUP;
      wait_r   <= STARTUP_RESET;
      sensor_r <= '0;
      rise_r   <= '0;
      fall_r   <= '0;
      trig_r   <= '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        width_r[i] <= '0;
      end
    end else begin
      phase_r  <= phase_nxt;
      wait_r   <= wait_nxt;
      sensor_r <= sensor_nxt;
      rise_r   <= rise_nxt;
      fall_r   <= fall_nxt;
      trig_r   <= trig_nxt;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        width_r[i] <= width_nxt[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `URRR_ASSERT_IMP(a_trig_onehot, clk, rst_n, 1'b1, $onehot0(trig_r))
  `URRR_ASSERT_IMP(a_trig_in_echo, clk, rst_n, trig_r != '0, phase_r == PH_ECHO)
  `URRR_ASSERT_IMP(a_sensor_range, clk, rst_n, 1'b1, sensor_r != 2'd3)
  `URRR_ASSERT_IMP(a_done_no_trig, clk, rst_n, out_valid_r && out_data_r.measure_done, out_data_r.trigger_lines == '0)
  `URRR_ASSERT_NXT(a_trig_to_echo, clk, rst_n, accept && (in_data.kind == KIND_TICK) && (phase_r == PH_TRIGGER), (phase_r == PH_ECHO) && (trig_r != '0))

endmodule

// ----- test/tb_ultrasonic_round_robin_ranger.sv -----
module tb_ultrasonic_round_robin_ranger;
  import urrr_pkg::*;

  // Request kind that the block ignores, and a register index with no register behind it
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [1:0] REG_SPARE  = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_t               out_data;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [PDATA_W-1:0] cfg_pwdata = '0;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  // Pending requests and ranging results still owed by the block
  in_t  request_q[$];
  out_t ranging_expect_q[$];

  // Mirror of the ranger state and its registers
  phase_t            rg_phase;
  logic [DATA_W-1:0] rg_count;
  logic [1:0]        rg_sensor;
  logic [DATA_W-1:0] rg_rise;
  logic [DATA_W-1:0] rg_fall;
  logic [DATA_W-1:0] rg_width [NUM_SENSORS];
  logic [2:0]        rg_trig;
  logic [DATA_W-1:0] cf_startup;
  logic [DATA_W-1:0] cf_echo;
  logic [DATA_W-1:0] cf_min;

  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  int unsigned stim_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned fault_cnt = 0;

  ultrasonic_round_robin_ranger u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Width above the limit, else no reading
  function automatic logic [DATA_W-1:0] gated_distance(logic [DATA_W-1:0] w);
    return (w > cf_min) ? w : NO_READING;
  endfunction

  // Smaller nonzero raw width of the two side sensors
  function automatic logic [DATA_W-1:0] closer_side();
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    a = rg_width[1];
    b = rg_width[2];
    if (a == '0 && b == '0) return NO_READING;
    if (a == '0) return b;
    if (b == '0) return a;
    return (a < b) ? a : b;
  endfunction

  // Advance the mirrored ranger by one request and form its result
  function automatic out_t advance_ranger(in_t req);
    out_t       res;
    logic [1:0] s;
    res = '0;
    s = (rg_sensor < NUM_SENSORS) ? rg_sensor : 2'd0;
    case (req.kind)
      KIND_RISE: rg_rise = req.capture_time;
      KIND_FALL: rg_fall = req.capture_time;
      KIND_TICK: begin
        if (rg_count != '0) rg_count = rg_count - 1'b1;
        case (rg_phase)
          PH_STARTUP: begin
            if (rg_count == '0) rg_phase = PH_TRIGGER;
          end
          PH_TRIGGER: begin
            rg_trig  = 3'b001 << s;
            rg_rise  = '0;
            rg_fall  = '0;
            rg_count = cf_echo;
            rg_phase = PH_ECHO;
          end
          PH_ECHO: begin
            if (rg_count == '0) begin
              res.pulse_width     = (rg_fall > rg_rise) ? rg_fall - rg_rise : '0;
              rg_width[s]         = res.pulse_width;
              res.measure_done    = 1'b1;
              res.measured_sensor = s;
              rg_sensor = (s == NUM_SENSORS - 1) ? 2'd0 : s + 2'd1;
              rg_phase  = PH_TRIGGER;
            end
            rg_trig = '0;
          end
          default: rg_phase = PH_STARTUP;
        endcase
      end
      default: ;
    endcase
    res.trigger_lines         = rg_trig;
    res.center_distance       = gated_distance(rg_width[0]);
    res.left_distance         = gated_distance(rg_width[1]);
    res.right_distance        = gated_distance(rg_width[2]);
    res.nearest_side_distance = closer_side();
    return res;
  endfunction

  // Mirror a register write; a start-up write during start-up reloads the counter
  function automatic void apply_register(logic [1:0] idx, logic [PDATA_W-1:0] word);
    case (idx)
      REG_STARTUP: begin
        cf_startup = word[DATA_W-1:0];
        if (rg_phase == PH_STARTUP) rg_count = word[DATA_W-1:0];
      end
      REG_ECHO_WAIT: cf_echo = word[DATA_W-1:0];
      REG_MIN_VALID: cf_min  = word[DATA_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      fault_cnt++;
      if (mismatch_cnt <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endfunction

  // Drive requests from the queue, with random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap != 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (request_q.size() != 0 && $urandom_range(0, 99) < in_idle_pct) begin
        in_gap   <= $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (request_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= request_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
      out_gap   <= 0;
    end else if (out_gap != 0) begin
      out_gap   <= out_gap - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < out_idle_pct) begin
      out_gap   <= $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) ranging_expect_q.push_back(advance_ranger(in_data));
      if (out_valid && out_ready) begin
        if (ranging_expect_q.size() == 0) begin
          fault_cnt++;
          $display("result with no request outstanding: %h", out_data);
        end else begin
          check_field("trigger_lines", 16'(ranging_expect_q[0].trigger_lines),
                      16'(out_data.trigger_lines));
          check_field("measure_done", 16'(ranging_expect_q[0].measure_done),
                      16'(out_data.measure_done));
          check_field("measured_sensor", 16'(ranging_expect_q[0].measured_sensor),
                      16'(out_data.measured_sensor));
          check_field("pulse_width", ranging_expect_q[0].pulse_width, out_data.pulse_width);
          check_field("center_distance", ranging_expect_q[0].center_distance,
                      out_data.center_distance);
          check_field("left_distance", ranging_expect_q[0].left_distance,
                      out_data.left_distance);
          check_field("right_distance", ranging_expect_q[0].right_distance,
                      out_data.right_distance);
          check_field("nearest_side_distance", ranging_expect_q[0].nearest_side_distance,
                      out_data.nearest_side_distance);
          void'(ranging_expect_q.pop_front());
        end
      end
    end
  end

  task automatic push_request(logic [1:0] k, logic [DATA_W-1:0] t);
    in_t r;
    r.kind         = k;
    r.capture_time = t;
    request_q.push_back(r);
    if (k != KIND_SPARE) stim_cnt++;
  endtask

  task automatic push_ticks(int unsigned n);
    repeat (n) push_request(KIND_TICK, 16'($urandom));
  endtask

  // Wait until every request is in and every result is out
  task automatic drain_wait();
    do @(posedge clk);
    while (request_q.size() != 0 || in_valid || ranging_expect_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [DATA_W-1:0] val);
    logic [PDATA_W-1:0] word;
    word = {16'($urandom), val};
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= PADDR_W'({idx, 2'b00});
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    apply_register(idx, word);
  endtask

  // One echo: rise and fall edges around the echo window, then a few ticks
  // (enough to finish when the echo wait is short)
  task automatic queue_echo_burst();
    logic [DATA_W-1:0] rise_t;
    logic [DATA_W-1:0] fall_t;
    rise_t = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
    case ($urandom_range(0, 7))
      0: fall_t = rise_t;
      1: fall_t = rise_t - 16'($urandom_range(1, 50));
      2: fall_t = 16'($urandom);
      3: fall_t = rise_t + cf_min;
      4: fall_t = rise_t + cf_min + 16'd1;
      default: fall_t = rise_t + 16'($urandom_range(1, 120));
    endcase
    if ($urandom_range(0, 4) == 0) begin
      push_request(KIND_FALL, fall_t);
      push_ticks($urandom_range(0, 1));
      push_request(KIND_RISE, rise_t);
    end else begin
      push_request(KIND_RISE, rise_t);
      push_ticks($urandom_range(0, 1));
      push_request(KIND_FALL, fall_t);
    end
    push_ticks($urandom_range(1, (cf_echo > 16'd6) ? 8 : int'(cf_echo) + 2));
  endtask

  task automatic run_random_phase(int unsigned n);
    int unsigned target;
    target = stim_cnt + n;
    while (stim_cnt < target) begin
      if ($urandom_range(0, 3) == 0)
        push_request(2'($urandom_range(0, 3)), 16'($urandom));
      else
        queue_echo_burst();
    end
    drain_wait();
  endtask

  initial begin
    int unsigned pct_set [3];
    int unsigned echo_set [6];
    pct_set  = '{0, 15, 40};
    echo_set = '{2, 0, 6, 1, 4, 3};

    // Hold the mirror in its reset state
    rg_phase   = PH_STARTUP;
    rg_count   = STARTUP_RESET;
    rg_sensor  = '0;
    rg_rise    = '0;
    rg_fall    = '0;
    rg_width   = '{default: '0};
    rg_trig    = '0;
    cf_startup = STARTUP_RESET;
    cf_echo    = ECHO_WAIT_RESET;
    cf_min     = MIN_VALID_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a tick, extreme edge times and the unused kind
    push_request(KIND_TICK, 16'h0000);
    push_request(KIND_RISE, 16'hFFFF);
    push_request(KIND_FALL, 16'h0000);
    push_request(KIND_SPARE, 16'($urandom));
    drain_wait();

    // Reload the start-up counter with the largest value, then with zero
    apb_write(REG_STARTUP, 16'hFFFF);
    push_request(KIND_TICK, 16'hFFFF);
    drain_wait();
    apb_write(REG_STARTUP, 16'h0000);
    apb_write(REG_ECHO_WAIT, 16'h0000);
    apb_write(REG_MIN_VALID, 16'h0000);
    apb_write(REG_SPARE, 16'($urandom));

    // Zero start-up and zero echo wait: one round over all sensors
    push_request(KIND_TICK, 16'h0000);
    push_request(KIND_TICK, 16'h0000);
    push_request(KIND_RISE, 16'd10);
    push_request(KIND_FALL, 16'd5);
    push_request(KIND_TICK, 16'h0000);
    push_request(KIND_TICK, 16'h0000);
    push_request(KIND_RISE, 16'h0000);
    push_request(KIND_FALL, 16'hFFFF);
    push_request(KIND_TICK, 16'h0000);
    push_request(KIND_TICK, 16'h0000);
    push_request(KIND_RISE, 16'd100);
    push_request(KIND_FALL, 16'd101);
    push_request(KIND_TICK, 16'h0000);
    drain_wait();

    // Largest threshold hides the center, left and right readings
    apb_write(REG_ECHO_WAIT, 16'd1);
    apb_write(REG_MIN_VALID, 16'hFFFF);
    push_request(KIND_TICK, 16'h0000);
    push_request(KIND_RISE, 16'h0000);
    push_request(KIND_FALL, 16'hFFFF);
    push_request(KIND_TICK, 16'h0000);
    drain_wait();

    // Random phases over a spread of settings
    for (int i = 0; i < 6; i++) begin
      apb_write(REG_STARTUP, 16'($urandom));
      apb_write(REG_ECHO_WAIT, 16'(echo_set[i]));
      if (i == 1)
        apb_write(REG_MIN_VALID, 16'h0000);
      else if (i == 2)
        apb_write(REG_MIN_VALID, 16'hFFFF);
      else
        apb_write(REG_MIN_VALID, 16'($urandom_range(0, 150)));
      in_idle_pct  = pct_set[$urandom_range(0, 2)];
      out_idle_pct = pct_set[$urandom_range(0, 2)];
      run_random_phase(125);
    end

    // Tail without idling; the longest echo wait never completes
    in_idle_pct  = 0;
    out_idle_pct = 0;
    apb_write(REG_ECHO_WAIT, 16'hFFFF);
    apb_write(REG_MIN_VALID, 16'($urandom_range(0, 80)));
    run_random_phase(80);

    repeat (4) @(posedge clk);
    if (ranging_expect_q.size() != 0) fault_cnt++;
    if (fault_cnt == 0) begin
      $display("tb_ultrasonic_round_robin_ranger OK");
    end else begin
      $display("tb_ultrasonic_round_robin_ranger NOT OK");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #3000000;
    $display("tb_ultrasonic_round_robin_ranger NOT OK");
    $finish;
  end

endmodule
